>>> hdl/mlmc_pkg.sv
// mlmc_pkg: shared constants and types for the matrix local-minimum counter
// no dependencies; used by mlmc_judge, the top level and the checker under hdl
`default_nettype none

package mlmc_pkg;

  // configuration register layout
  localparam int CFG_W      = 7;    // matrix_size register width
  localparam int APB_AW     = 3;    // byte address, one 32-bit register
  localparam int APB_DW     = 32;
  localparam int CNT_W      = 13;   // local_min_count width
  localparam int SIZE_RESET = 8;    // matrix_size after reset

  // register index, taken from paddr[2]
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // position flags of one element, carried down the pipeline
  typedef struct packed {
    logic r_ge1;   // row >= 1
    logic r_ge2;   // row >= 2
    logic c_ge1;   // column >= 1
    logic c_ge2;   // column >= 2
    logic r_last;  // last row
    logic c_last;  // last column
  } pos_flags_t;

endpackage

`default_nettype wire

>>> hdl/mlmc_line_mem.sv
// mlmc_line_mem: line buffer storage, one word per column holding the two previous rows
// registered read with write-to-read forwarding; no package dependency
`default_nettype none

module mlmc_line_mem #(
  parameter int DEPTH = 64,
  parameter int DW    = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_q;

  // write port and registered read; a same-address write is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> hdl/mlmc_win_col.sv
// mlmc_win_col: one column of the 3x3 window, three values from top to bottom
// hands its column to the left neighbor on every shift; no package dependency
`default_nettype none

module mlmc_win_col #(
  parameter int VW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 shift_i,
  input  wire logic signed [VW-1:0] col_i [3],
  output logic signed      [VW-1:0] col_o [3]
);

  logic signed [VW-1:0] val_q [3];

  // take the column from the right neighbor
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= col_i;
    end
  end

  assign col_o = val_q;

endmodule

`default_nettype wire

>>> hdl/mlmc_judge.sv
// mlmc_judge: decides up to four window centers and counts the local minima
// depends on mlmc_pkg (pos_flags_t)
`default_nettype none

module mlmc_judge #(
  parameter int VW = 16
) (
  input  wire logic signed [VW-1:0] win_i [9],  // row-major 3x3 window
  input  wire mlmc_pkg::pos_flags_t flags_i,
  output logic             [2:0]    inc_o
);

  logic [2:0] vrow;
  logic [2:0] vcol;
  logic [3:0] judge_en;
  logic [3:0] is_min;

  // window rows and columns that lie inside the matrix
  assign vrow = {1'b1, flags_i.r_ge1, flags_i.r_ge2};
  assign vcol = {1'b1, flags_i.c_ge1, flags_i.c_ge2};

  // centers: bit0 (1,1), bit1 (1,2), bit2 (2,1), bit3 (2,2)
  assign judge_en[0] = flags_i.r_ge1  & flags_i.c_ge1;
  assign judge_en[1] = flags_i.r_ge1  & flags_i.c_last;
  assign judge_en[2] = flags_i.r_last & flags_i.c_ge1;
  assign judge_en[3] = flags_i.r_last & flags_i.c_last;

  // no in-bounds neighbor strictly smaller than the center
  always_comb begin
    int cr;
    int cc;
    is_min = '1;
    for (int k = 0; k < 4; k++) begin
      cr = 1 + k / 2;
      cc = 1 + k % 2;
      for (int wi = 0; wi < 3; wi++) begin
        for (int wj = 0; wj < 3; wj++) begin
          if ((wi >= cr - 1) && (wj >= cc - 1) && vrow[wi] && vcol[wj] &&
              (win_i[wi*3 + wj] < win_i[cr*3 + cc])) begin
            is_min[k] = 1'b0;
          end
        end
      end
    end
  end

  // count of decided minima for this element
  always_comb begin
    logic [3:0] hit;
    hit   = is_min & judge_en;
    inc_o = {2'b00, hit[0]} + {2'b00, hit[1]} + {2'b00, hit[2]} + {2'b00, hit[3]};
  end

endmodule

`default_nettype wire

>>> hdl/matrix_local_minimum_counter_top.sv
// matrix_local_minimum_counter_top: streams a square matrix and counts 3x3 local minima
// depends on mlmc_pkg, mlmc_line_mem, mlmc_win_col, mlmc_judge
//
//  channel   signals                                     direction  payload
//  input     in_valid_i / in_ready_o                     in         element_value_i
//  result    out_valid_o / out_ready_i                   out        local_min_count_o
//  config    psel penable pwrite paddr pwdata / prdata   in / out   matrix_size at 0x0
//
// one element per cycle while in_ready_o is high; position counters, then the line
// buffer read and element registers, then the window cells and judge (3-stage pipe)
// the final element's window is judged and its count is registered onto out_valid_o
// reset clears position, tally and pipeline valids; no clearing pass is needed
// input stalls only while a count waits unaccepted and the next count is due
`default_nettype none

module matrix_local_minimum_counter_top #(
  parameter int MAX_SIZE    = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlmc_pkg::APB_AW-1:0]     paddr,
  input  wire logic [mlmc_pkg::APB_DW-1:0]     pwdata,
  output logic      [mlmc_pkg::APB_DW-1:0]     prdata,
  output logic                                 pready,
  // element input
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0]   element_value_i,
  // count output
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [mlmc_pkg::CNT_W-1:0]      local_min_count_o
);

  localparam int PW      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int RST_NM1 = ((mlmc_pkg::SIZE_RESET > MAX_SIZE) ? MAX_SIZE
                                                               : mlmc_pkg::SIZE_RESET) - 1;
  localparam int CW      = mlmc_pkg::CFG_W;
  localparam int NW      = mlmc_pkg::CNT_W;

  // configuration register
  logic                cfg_wr;
  logic [CW-1:0]       wsize;
  logic [CW-1:0]       size_q;
  logic [PW-1:0]       nm1_q, nm1_d;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready &
                  (paddr[2] == mlmc_pkg::REG_MATRIX_SIZE);
  assign wsize  = pwdata[CW-1:0];
  assign prdata = {{(mlmc_pkg::APB_DW-CW){1'b0}}, size_q};

  // clamp the side length, kept as side minus one
  always_comb begin
    if (wsize == '0) begin
      nm1_d = '0;
    end else if (32'(wsize) > MAX_SIZE) begin
      nm1_d = PW'(MAX_SIZE - 1);
    end else begin
      nm1_d = PW'(wsize - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CW'(mlmc_pkg::SIZE_RESET);
      nm1_q  <= PW'(RST_NM1);
    end else if (cfg_wr) begin
      size_q <= wsize;
      nm1_q  <= nm1_d;
    end
  end

  // pipeline control
  logic                 en;
  logic                 acc;
  logic                 s1_valid_q, s2_valid_q;
  mlmc_pkg::pos_flags_t s0_flags, s1_flags_q, s2_flags_q;
  logic                 out_valid_q;
  logic [NW-1:0]        out_q;

  assign en         = !(s2_valid_q && s2_flags_q.r_last && s2_flags_q.c_last &&
                        out_valid_q && !out_ready_i);
  assign in_ready_o = en;
  assign acc        = in_valid_i & en;

  // position counters, stage 0
  logic [PW-1:0] row_q, col_q;

  always_comb begin
    s0_flags.r_ge1  = (row_q != '0);
    s0_flags.r_ge2  = (row_q > PW'(1));
    s0_flags.c_ge1  = (col_q != '0);
    s0_flags.c_ge2  = (col_q > PW'(1));
    s0_flags.r_last = (row_q == nm1_q);
    s0_flags.c_last = (col_q == nm1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_wr) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      if (s0_flags.c_last) begin
        col_q <= '0;
        row_q <= s0_flags.r_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // stage 1 registers: element, column and flags while the line buffer is read
  logic signed [VALUE_WIDTH-1:0] s1_val_q;
  logic        [PW-1:0]          s1_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_val_q   <= element_value_i;
      s1_addr_q  <= col_q;
      s1_flags_q <= s0_flags;
    end
    if (en && s1_valid_q) begin
      s2_flags_q <= s1_flags_q;
    end
  end

  // line buffers: upper row in the high half, middle row in the low half
  logic [2*VALUE_WIDTH-1:0] lb_rd;
  logic                     lb_wr;

  assign lb_wr = en & s1_valid_q;

  mlmc_line_mem #(
    .DEPTH (MAX_SIZE),
    .DW    (2*VALUE_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (col_q),
    .rd_data_o (lb_rd),
    .wr_en_i   (lb_wr),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({lb_rd[VALUE_WIDTH-1:0], s1_val_q})
  );

  // window: chain of three column cells, right column fed from the line buffers
  logic signed [VALUE_WIDTH-1:0] col_in  [3][3];
  logic signed [VALUE_WIDTH-1:0] win_col [3][3];
  logic signed [VALUE_WIDTH-1:0] win     [9];

  always_comb begin
    col_in[2][0] = lb_rd[2*VALUE_WIDTH-1:VALUE_WIDTH];
    col_in[2][1] = lb_rd[VALUE_WIDTH-1:0];
    col_in[2][2] = s1_val_q;
    col_in[1]    = win_col[2];
    col_in[0]    = win_col[1];
  end

  for (genvar j = 0; j < 3; j++) begin : g_col
    mlmc_win_col #(
      .VW (VALUE_WIDTH)
    ) u_col (
      .clk_i   (clk_i),
      .shift_i (lb_wr),
      .col_i   (col_in[j]),
      .col_o   (win_col[j])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i*3 + j] = win_col[j][i];
      end
    end
  end

  // stage 2: judge the window and update the tally
  logic [2:0]    inc;
  logic [NW-1:0] tally_q;
  logic [NW-1:0] tally_sum;

  mlmc_judge #(
    .VW (VALUE_WIDTH)
  ) u_judge (
    .win_i   (win),
    .flags_i (s2_flags_q),
    .inc_o   (inc)
  );

  assign tally_sum = tally_q + NW'(inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
    end else if (cfg_wr) begin
      tally_q <= '0;
    end else if (en && s2_valid_q) begin
      if (s2_flags_q.r_last && s2_flags_q.c_last) begin
        tally_q <= '0;
      end else begin
        tally_q <= tally_sum;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && s2_valid_q && s2_flags_q.r_last && s2_flags_q.c_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q && s2_flags_q.r_last && s2_flags_q.c_last) begin
      out_q <= tally_sum;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign local_min_count_o = out_q;

endmodule

`default_nettype wire

>>> hdl/mlmc_checker.sv
// mlmc_sva_checker: port-level checks for matrix_local_minimum_counter_top
// depends on mlmc_pkg; bound to the top level at the end of this file
`default_nettype none

module mlmc_sva_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [mlmc_pkg::APB_AW-1:0]  paddr,
  input wire logic [mlmc_pkg::APB_DW-1:0]  pwdata,
  input wire logic [mlmc_pkg::APB_DW-1:0]  prdata,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [mlmc_pkg::CNT_W-1:0]   local_min_count_o
);

  // a stalled count transfer keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(local_min_count_o))
    else $error("count changed or dropped while stalled");

  // every matrix has at least one local minimum (its smallest element)
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> local_min_count_o != '0)
    else $error("zero local minima reported");

  // input is held back only by a waiting count
  a_ready_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a size write reads back on the next cycle
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && (paddr[2] == mlmc_pkg::REG_MATRIX_SIZE)
    |=> prdata[mlmc_pkg::CFG_W-1:0] == $past(pwdata[mlmc_pkg::CFG_W-1:0]))
    else $error("matrix_size readback mismatch");

endmodule

bind matrix_local_minimum_counter_top mlmc_sva_checker u_mlmc_sva_checker (.*);

`default_nettype wire

>>> sim/mlmc_checker.sv
`timescale 1ns / 1ps
// mlmc_checker: watches the config, element and count channels of the
// local-minimum counter, predicts every count and compares it on transfer
// depends on mlmc_pkg
module mlmc_checker #(
  parameter int MAX_SIZE    = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [mlmc_pkg::APB_AW-1:0]         paddr,
  input  logic [mlmc_pkg::APB_DW-1:0]         pwdata,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0]       element_value_i,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic [mlmc_pkg::CNT_W-1:0]          local_min_count_o,
  output int                                  error_count_o,
  output int                                  pending_count_o,
  output int                                  elements_seen_o,
  output int                                  counts_seen_o
);

  localparam int   CFG_W           = mlmc_pkg::CFG_W;
  localparam int   CNT_W           = mlmc_pkg::CNT_W;
  localparam int   APB_AW          = mlmc_pkg::APB_AW;
  localparam int   SIZE_RESET      = mlmc_pkg::SIZE_RESET;
  localparam logic REG_MATRIX_SIZE = mlmc_pkg::REG_MATRIX_SIZE;

  // predicted block state
  logic [CFG_W-1:0]              size_reg;
  int                            row_pos;
  int                            col_pos;
  int                            side;
  logic signed [VALUE_WIDTH-1:0] grid [MAX_SIZE][MAX_SIZE];
  logic [CNT_W-1:0]              expected_counts [$];
  logic [CNT_W-1:0]              oldest_count;
  int                            mismatches;
  int                            elements;
  int                            counts;

  // a cell counts when no in-bounds neighbor is strictly smaller
  function automatic int count_local_minima(input int n);
    int  tally;
    int  r;
    int  c;
    int  dr;
    int  dc;
    int  nr;
    int  nc;
    logic is_min;
    tally = 0;
    for (r = 0; r < n; r++) begin
      for (c = 0; c < n; c++) begin
        is_min = 1'b1;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if (nr >= 0 && nr < n && nc >= 0 && nc < n) begin
              if (grid[nr][nc] < grid[r][c]) is_min = 1'b0;
            end
          end
        end
        if (is_min) tally++;
      end
    end
    return tally;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg   = CFG_W'(SIZE_RESET);
      row_pos    = 0;
      col_pos    = 0;
      mismatches = 0;
      elements   = 0;
      counts     = 0;
      expected_counts.delete();
    end else begin
      // size write restarts the matrix, other addresses are ignored
      if (psel && penable && pwrite && pready &&
          paddr[APB_AW-1:2] == REG_MATRIX_SIZE) begin
        size_reg = pwdata[CFG_W-1:0];
        row_pos  = 0;
        col_pos  = 0;
      end

      // element transfer: store in row-major place, count on the final one
      if (in_valid_i && in_ready_o) begin
        elements++;
        if (size_reg == 0) side = 1;
        else if (size_reg > MAX_SIZE) side = MAX_SIZE;
        else side = size_reg;
        if (row_pos >= side || col_pos >= side) begin
          row_pos = 0;
          col_pos = 0;
        end
        grid[row_pos][col_pos] = element_value_i;
        if (col_pos + 1 < side) begin
          col_pos++;
        end else begin
          col_pos = 0;
          if (row_pos + 1 < side) begin
            row_pos++;
          end else begin
            row_pos = 0;
            expected_counts.push_back(CNT_W'(count_local_minima(side)));
          end
        end
      end

      // count transfer against the oldest prediction
      if (out_valid_o && out_ready_i) begin
        counts++;
        if (expected_counts.size() == 0) begin
          mismatches++;
          $display("%0t: local_min_count with none expected: expected none, actual %0d",
                   $time, local_min_count_o);
        end else begin
          oldest_count = expected_counts.pop_front();
          if (local_min_count_o !== oldest_count) begin
            mismatches++;
            $display("%0t: local_min_count mismatch: expected %0d, actual %0d",
                     $time, oldest_count, local_min_count_o);
          end
        end
      end
    end
    error_count_o   <= mismatches;
    pending_count_o <= expected_counts.size();
    elements_seen_o <= elements;
    counts_seen_o   <= counts;
  end

endmodule

>>> sim/tb_matrix_local_minimum_counter_top.sv
`timescale 1ns / 1ps
// tb_matrix_local_minimum_counter_top: stimulus and verdict for the
// local-minimum counter; depends on mlmc_pkg, mlmc_checker and the RTL top
module tb_matrix_local_minimum_counter_top;

  localparam int   APB_AW          = mlmc_pkg::APB_AW;
  localparam int   APB_DW          = mlmc_pkg::APB_DW;
  localparam int   CFG_W           = mlmc_pkg::CFG_W;
  localparam int   CNT_W           = mlmc_pkg::CNT_W;
  localparam int   SIZE_RESET      = mlmc_pkg::SIZE_RESET;
  localparam logic REG_MATRIX_SIZE = mlmc_pkg::REG_MATRIX_SIZE;

  localparam int MAX_SIZE    = 64;
  localparam int VALUE_WIDTH = 16;
  localparam int CLK_PERIOD  = 4;
  localparam int PIPE_SETTLE = 8;     // cycles for the pipe to empty
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer at all

  localparam logic [APB_AW-1:0] SIZE_ADDR   = {REG_MATRIX_SIZE, 2'b00};
  localparam logic [APB_AW-1:0] UNUSED_ADDR = {~REG_MATRIX_SIZE, 2'b00};

  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = ~VALUE_MIN;

  typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_FLAT} fill_style_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [APB_AW-1:0]             paddr = '0;
  logic [APB_DW-1:0]             pwdata = '0;
  logic [APB_DW-1:0]             prdata;
  logic                          pready;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [VALUE_WIDTH-1:0] element_value_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [CNT_W-1:0]              local_min_count_o;

  int mismatches;
  int pending_counts;
  int elements_seen;
  int counts_seen;
  int send_idle_pct = 17;
  int recv_idle_pct = 65;
  int side = SIZE_RESET;
  int stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  matrix_local_minimum_counter_top #(
    .MAX_SIZE    (MAX_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .element_value_i   (element_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .local_min_count_o (local_min_count_o)
  );

  mlmc_checker #(
    .MAX_SIZE    (MAX_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .element_value_i   (element_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .local_min_count_o (local_min_count_o),
    .error_count_o     (mismatches),
    .pending_count_o   (pending_counts),
    .elements_seen_o   (elements_seen),
    .counts_seen_o     (counts_seen)
  );

  // count receiver with random back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int side_of(input logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SIZE) return MAX_SIZE;
    return raw;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input fill_style_e style);
    case (style)
      FILL_NARROW: return VALUE_WIDTH'(int'($urandom_range(4)) - 2);
      FILL_EXTREME: begin
        case ($urandom_range(2))
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          default: return '0;
        endcase
      end
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  // one element transfer; valid stays up between back-to-back elements
  task automatic send_element(input logic signed [VALUE_WIDTH-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_matrix(input fill_style_e style);
    logic signed [VALUE_WIDTH-1:0] flat_value;
    flat_value = VALUE_WIDTH'($urandom);
    repeat (side * side) begin
      send_element(style == FILL_FLAT ? flat_value : pick_value(style));
    end
  endtask

  // wait until every count is out and the pipe has emptied
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_counts != 0) @(posedge clk_i);
    repeat (PIPE_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // new matrix size with random upper data bits
  task automatic set_size(input logic [CFG_W-1:0] raw);
    logic [APB_DW-1:0] data;
    data            = $urandom;
    data[CFG_W-1:0] = raw;
    drain();
    write_reg(SIZE_ADDR, data);
    side = side_of(raw);
  endtask

  function automatic logic [CFG_W-1:0] random_size_raw();
    case ($urandom_range(9))
      0:       return '0;
      1, 2:    return CFG_W'($urandom_range(4, 2));
      3:       return CFG_W'($urandom_range(12, 7));
      default: return CFG_W'($urandom_range(6, 1));
    endcase
  endfunction

  initial begin
    int          phase;
    int          phase_items;
    int          phase_matrices;
    int          cut;
    fill_style_e style;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // partial matrix at the reset size, then a restart by size write
    send_element(VALUE_MIN);
    send_element(VALUE_MAX);
    send_element('0);
    send_element(-1);
    send_element(1);
    set_size(2);

    // 2x2 with extremes; an unused address write mid-matrix changes nothing
    send_element(VALUE_MIN);
    send_element(VALUE_MAX);
    drain();
    write_reg(UNUSED_ADDR, $urandom);
    send_element(VALUE_MAX);
    send_element(VALUE_MIN);

    // size zero acts as one, single element counts at once
    set_size(0);
    send_element(VALUE_MAX);
    set_size(1);
    send_element(VALUE_MIN);

    // flat 3x3: all ties count
    set_size(3);
    repeat (9) send_element(-5);

    // random matrices over three idling phases
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 65;
        end
        1: begin
          send_idle_pct = 65;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_items    = 0;
      phase_matrices = 0;
      while (phase_items < 115 || phase_matrices < 4) begin
        style = fill_style_e'($urandom_range(FILL_FLAT));
        if ($urandom_range(2) == 0) set_size(random_size_raw());
        if ($urandom_range(9) == 0 && side > 1) begin
          // broken matrix: cut short and restarted by a size write
          cut = $urandom_range(side * side - 1, 1);
          repeat (cut) send_element(pick_value(style));
          phase_items += cut;
          set_size(random_size_raw());
        end else begin
          send_matrix(style);
          phase_items += side * side;
          phase_matrices++;
        end
      end
    end

    drain();
    $display("run covered %0d element transfers and %0d count transfers,",
             elements_seen, counts_seen);
    $display("sizes 0 to 12, ties, extremes, restarts and both-side stalls");
    if (mismatches == 0 && pending_counts == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
